@@ rtl/ecs_pkg.sv @@
// Shared types, constants and arithmetic helpers for the sensor compensation block.
package ecs_pkg;

  localparam int unsigned DivSteps = 32;

  localparam logic [31:0] TempOffset  = 32'd64000;
  localparam logic [31:0] PressBase   = 32'd1048576;
  localparam logic [31:0] PressScale  = 32'd3125;
  localparam logic [31:0] HumOffset   = 32'd76800;
  localparam logic [31:0] HumRound    = 32'd16384;
  localparam logic [31:0] HalfScale   = 32'd32768;
  localparam logic [31:0] HumBias     = 32'd2097152;
  localparam logic [31:0] HumRoundB   = 32'd8192;
  localparam logic [31:0] HumMax      = 32'd419430400;
  localparam logic [63:0] RecipHundred = 64'd1374389535;

  typedef enum logic [2:0] {
    CfgTemp      = 3'd0,
    CfgPressLow  = 3'd1,
    CfgPressHigh = 3'd2,
    CfgPressNine = 3'd3,
    CfgHumLow    = 3'd4,
    CfgHumHigh   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [19:0] temp_reading;
    logic [19:0] press_reading;
    logic [15:0] hum_reading;
  } in_t;

  typedef struct packed {
    logic signed [31:0] temp_centi;
    logic [25:0]        press_scaled;
    logic [6:0]         hum_percent;
    logic               press_div_zero;
  } out_t;

  typedef struct packed {
    logic [31:0] temp;
    logic [31:0] hv;
    logic        div_zero;
    logic        dbl;
  } side_t;

  function automatic logic [31:0] sx16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sx8(logic [7:0] v);
    return {{24{v[7]}}, v};
  endfunction

  function automatic logic [31:0] asr(logic [31:0] x, int unsigned n);
    return 32'($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] mul32(logic [31:0] a, logic [31:0] b);
    logic [63:0] p;
    p = {32'd0, a} * {32'd0, b};
    return p[31:0];
  endfunction

endpackage

@@ rtl/ecs_div.sv @@
// Pipelined restoring divider, one quotient bit per stage, with a sideband word.
module ecs_div (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [31:0]   dvd_i,
  input  logic [31:0]   den_i,
  input  ecs_pkg::side_t side_i,
  output logic          valid_o,
  output logic [31:0]   quo_o,
  output ecs_pkg::side_t side_o
);
  import ecs_pkg::*;

  logic [DivSteps:1] vld_q;
  logic [31:0]       rem_q [DivSteps+1];
  logic [31:0]       dvd_q [DivSteps+1];
  logic [31:0]       den_q [DivSteps+1];
  side_t             side_q [DivSteps+1];

  always_comb begin
    rem_q[0]  = '0;
    dvd_q[0]  = dvd_i;
    den_q[0]  = den_i;
    side_q[0] = side_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[DivSteps-1:1], valid_i};
    end
  end

  for (genvar k = 0; k < DivSteps; k++) begin : g_step
    logic [32:0] trial;
    assign trial = {rem_q[k], dvd_q[k][31]} - {1'b0, den_q[k]};
    always_ff @(posedge clk_i) begin
      if (trial[32]) begin
        rem_q[k+1] <= {rem_q[k][30:0], dvd_q[k][31]};
      end else begin
        rem_q[k+1] <= trial[31:0];
      end
      dvd_q[k+1]  <= {dvd_q[k][30:0], ~trial[32]};
      den_q[k+1]  <= den_q[k];
      side_q[k+1] <= side_q[k];
    end
  end

  assign valid_o = vld_q[DivSteps];
  assign quo_o   = dvd_q[DivSteps];
  assign side_o  = side_q[DivSteps];

endmodule

@@ rtl/env_sensor_compensation_32bit.sv @@
// Top level of the environmental sensor compensation pipeline.
// Usage:
// A sample word (raw temperature, pressure and humidity) is taken at each
// rising edge with start_i high and busy_o low. busy_o is always low, so a
// new word may be offered in every cycle.
// Each result word appears on out_o for one cycle with valid_o high, one
// result per sample, in order. Throughput is one word per cycle; there are
// 8 arithmetic stages, a 32-stage pipelined divider for pressure and 4
// finishing stages. Coefficients are written through cfg_we_i, cfg_idx_i
// and cfg_data_i; the user must write them only while no samples are in
// flight, which the block does not enforce; unknown indexes are ignored.
// Reset clears all coefficients and empties the pipeline.
// The receiver cannot stall; results must be taken when valid_o is high.
module env_sensor_compensation_32bit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  output logic          busy_o,
  input  ecs_pkg::in_t  in_i,
  output logic          valid_o,
  output ecs_pkg::out_t out_o,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_idx_i,
  input  logic [63:0]   cfg_data_i
);
  import ecs_pkg::*;

  logic [47:0] temp_coeffs_q;
  logic [63:0] press_low_q, press_high_q;
  logic [15:0] press_nine_q;
  logic [31:0] hum_low_q;
  logic [39:0] hum_high_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_coeffs_q <= '0;
      press_low_q   <= '0;
      press_high_q  <= '0;
      press_nine_q  <= '0;
      hum_low_q     <= '0;
      hum_high_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgTemp:      temp_coeffs_q <= cfg_data_i[47:0];
        CfgPressLow:  press_low_q   <= cfg_data_i;
        CfgPressHigh: press_high_q  <= cfg_data_i;
        CfgPressNine: press_nine_q  <= cfg_data_i[15:0];
        CfgHumLow:    hum_low_q     <= cfg_data_i[31:0];
        CfgHumHigh:   hum_high_q    <= cfg_data_i[39:0];
        default: ;
      endcase
    end
  end

  logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, h1, h2, h3, h4, h5, h6;
  assign t1 = {16'd0, temp_coeffs_q[15:0]};
  assign t2 = sx16(temp_coeffs_q[31:16]);
  assign t3 = sx16(temp_coeffs_q[47:32]);
  assign p1 = {16'd0, press_low_q[15:0]};
  assign p2 = sx16(press_low_q[31:16]);
  assign p3 = sx16(press_low_q[47:32]);
  assign p4 = sx16(press_low_q[63:48]);
  assign p5 = sx16(press_high_q[15:0]);
  assign p6 = sx16(press_high_q[31:16]);
  assign p7 = sx16(press_high_q[47:32]);
  assign p8 = sx16(press_high_q[63:48]);
  assign p9 = sx16(press_nine_q);
  assign h1 = {24'd0, hum_low_q[7:0]};
  assign h2 = sx16(hum_low_q[23:8]);
  assign h3 = {24'd0, hum_low_q[31:24]};
  assign h4 = sx16(hum_high_q[15:0]);
  assign h5 = sx16(hum_high_q[31:16]);
  assign h6 = sx8(hum_high_q[39:32]);

  assign busy_o = 1'b0;

  logic accept;
  assign accept = start_i && !busy_o;

  logic [8:1] sv_q;
  logic [4:1] pv_q;

  // Front stages.
  logic [31:0] adc_t, s1_a, s1_d;
  assign adc_t = {12'd0, in_i.temp_reading};
  assign s1_a  = (adc_t >> 3) - (t1 << 1);
  assign s1_d  = (adc_t >> 4) - t1;

  logic [31:0] s1_m1_q, s1_m2_q, s1_adcp_q, s1_adch_q;
  logic [31:0] s2_v1_q, s2_m3_q, s2_adcp_q, s2_adch_q;
  logic [31:0] s3_tf_q, s3_adcp_q, s3_adch_q;
  logic [31:0] s4_temp_q, s4_sq_q, s4_hma_q, s4_hm6_q, s4_hm3_q, s4_pm5_q, s4_pm2_q;
  logic [31:0] s4_adcp_q, s4_adch_q;
  logic [31:0] s5_v2a_q, s5_m3p_q, s5_pm5_q, s5_pm2_q, s5_ha_q, s5_hb_q, s5_temp_q, s5_adcp_q;
  logic [31:0] s6_v2_q, s6_pv1_q, s6_hbm_q, s6_ha_q, s6_temp_q, s6_adcp_q;
  logic [31:0] s7_pm_q, s7_hbb_q, s7_np_q, s7_ha_q, s7_temp_q;
  logic [31:0] s8_den_q, s8_num_q, s8_hv_q, s8_temp_q;

  logic [31:0] s4_tf_pv1, s4_tf_hv1, s4_dq;
  assign s4_tf_pv1 = asr(s3_tf_q, 1) - TempOffset;
  assign s4_tf_hv1 = s3_tf_q - HumOffset;
  assign s4_dq     = asr(s4_tf_pv1, 2);

  always_ff @(posedge clk_i) begin
    s1_m1_q   <= mul32(s1_a, t2);
    s1_m2_q   <= mul32(s1_d, s1_d);
    s1_adcp_q <= {12'd0, in_i.press_reading};
    s1_adch_q <= {16'd0, in_i.hum_reading};

    s2_v1_q   <= asr(s1_m1_q, 11);
    s2_m3_q   <= mul32(asr(s1_m2_q, 12), t3);
    s2_adcp_q <= s1_adcp_q;
    s2_adch_q <= s1_adch_q;

    s3_tf_q   <= s2_v1_q + asr(s2_m3_q, 14);
    s3_adcp_q <= s2_adcp_q;
    s3_adch_q <= s2_adch_q;

    s4_temp_q <= asr((s3_tf_q << 2) + s3_tf_q + 32'd128, 8);
    s4_sq_q   <= mul32(s4_dq, s4_dq);
    s4_hma_q  <= mul32(h5, s4_tf_hv1);
    s4_hm6_q  <= mul32(s4_tf_hv1, h6);
    s4_hm3_q  <= mul32(s4_tf_hv1, h3);
    s4_pm5_q  <= mul32(s4_tf_pv1, p5);
    s4_pm2_q  <= mul32(p2, s4_tf_pv1);
    s4_adcp_q <= s3_adcp_q;
    s4_adch_q <= s3_adch_q;

    s5_v2a_q  <= mul32(asr(s4_sq_q, 11), p6);
    s5_m3p_q  <= mul32(p3, asr(s4_sq_q, 13));
    s5_ha_q   <= asr((s4_adch_q << 14) - (h4 << 20) - s4_hma_q + HumRound, 15);
    s5_hb_q   <= mul32(asr(s4_hm6_q, 10), asr(s4_hm3_q, 11) + HalfScale);
    s5_pm5_q  <= s4_pm5_q;
    s5_pm2_q  <= s4_pm2_q;
    s5_temp_q <= s4_temp_q;
    s5_adcp_q <= s4_adcp_q;

    s6_v2_q   <= asr(s5_v2a_q + (s5_pm5_q << 1), 2) + (p4 << 16);
    s6_pv1_q  <= asr(asr(s5_m3p_q, 3) + asr(s5_pm2_q, 1), 18);
    s6_hbm_q  <= mul32(asr(s5_hb_q, 10) + HumBias, h2);
    s6_ha_q   <= s5_ha_q;
    s6_temp_q <= s5_temp_q;
    s6_adcp_q <= s5_adcp_q;

    s7_pm_q   <= mul32(HalfScale + s6_pv1_q, p1);
    s7_hbb_q  <= asr(s6_hbm_q + HumRoundB, 14);
    s7_np_q   <= (PressBase - s6_adcp_q) - asr(s6_v2_q, 12);
    s7_ha_q   <= s6_ha_q;
    s7_temp_q <= s6_temp_q;

    s8_den_q  <= asr(s7_pm_q, 15);
    s8_num_q  <= mul32(s7_np_q, PressScale);
    s8_hv_q   <= mul32(s7_ha_q, s7_hbb_q);
    s8_temp_q <= s7_temp_q;
  end

  // Divider.
  side_t       div_side_in, div_side;
  logic        div_valid;
  logic [31:0] div_quo, div_dvd, div_den;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q <= '0;
      pv_q <= '0;
    end else begin
      sv_q <= {sv_q[7:1], accept};
      pv_q <= {pv_q[3:1], div_valid};
    end
  end

  always_comb begin
    div_side_in.temp     = s8_temp_q;
    div_side_in.hv       = s8_hv_q;
    div_side_in.div_zero = (s8_den_q == 32'd0);
    div_side_in.dbl      = !s8_num_q[31];
    div_dvd = div_side_in.dbl ? (s8_num_q << 1) : s8_num_q;
    div_den = div_side_in.div_zero ? 32'd1 : s8_den_q;
  end

  ecs_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sv_q[8]),
    .dvd_i   (div_dvd),
    .den_i   (div_den),
    .side_i  (div_side_in),
    .valid_o (div_valid),
    .quo_o   (div_quo),
    .side_o  (div_side)
  );

  // Finishing stages.
  logic [31:0] pq;
  assign pq = div_side.dbl ? div_quo : (div_quo << 1);

  logic [31:0] p1_pq_q, p1_mm_q, p1_v2m_q, p1_ss_q, p1_hv_q, p1_temp_q;
  logic        p1_zero_q, p2_zero_q, p3_zero_q, p4_zero_q;
  logic [31:0] p2_pq_q, p2_v1_q, p2_v2m_q, p2_hm_q, p2_hv_q, p2_temp_q;
  logic [31:0] p3_p_q, p3_temp_q, p4_temp_q;
  logic [6:0]  p3_hum_q, p4_hum_q;
  logic [63:0] p4_prod_q;

  logic [31:0] p1_s, p1_d, p3_v, p3_vc;
  assign p1_s = asr(div_side.hv, 15);
  assign p1_d = pq >> 3;
  assign p3_v = p2_hv_q - asr(p2_hm_q, 4);

  always_comb begin
    if (p3_v[31]) begin
      p3_vc = '0;
    end else if (p3_v > HumMax) begin
      p3_vc = HumMax;
    end else begin
      p3_vc = p3_v;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_pq_q   <= pq;
    p1_mm_q   <= mul32(p1_d, p1_d) >> 13;
    p1_v2m_q  <= mul32(pq >> 2, p8);
    p1_ss_q   <= mul32(p1_s, p1_s);
    p1_hv_q   <= div_side.hv;
    p1_temp_q <= div_side.temp;
    p1_zero_q <= div_side.div_zero;

    p2_pq_q   <= p1_pq_q;
    p2_v1_q   <= asr(mul32(p9, p1_mm_q), 12);
    p2_v2m_q  <= p1_v2m_q;
    p2_hm_q   <= mul32(asr(p1_ss_q, 7), h1);
    p2_hv_q   <= p1_hv_q;
    p2_temp_q <= p1_temp_q;
    p2_zero_q <= p1_zero_q;

    p3_p_q    <= p2_pq_q + asr(p2_v1_q + asr(p2_v2m_q, 13) + p7, 4);
    p3_hum_q  <= p3_vc[28:22];
    p3_temp_q <= p2_temp_q;
    p3_zero_q <= p2_zero_q;

    p4_prod_q <= {32'd0, p3_p_q} * RecipHundred;
    p4_hum_q  <= p3_hum_q;
    p4_temp_q <= p3_temp_q;
    p4_zero_q <= p3_zero_q;
  end

  always_comb begin
    out_o.temp_centi     = p4_temp_q;
    out_o.press_scaled   = p4_zero_q ? 26'd0 : p4_prod_q[62:37];
    out_o.hum_percent    = p4_hum_q;
    out_o.press_div_zero = p4_zero_q;
  end

  assign valid_o = pv_q[4];

endmodule

@@ verif/tb.sv @@
// Testbench for the environmental sensor compensation block: predicted results against the pipeline.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ecs_pkg::*;

  localparam int unsigned Latency = 44;
  localparam longint unsigned CycleLimit = 400000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic        busy_o;
  in_t         in_i = '0;
  logic        valid_o;
  out_t        out_o;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_idx_i = '0;
  logic [63:0] cfg_data_i = '0;

  logic [47:0] temp_cal;
  logic [63:0] press_cal_lo;
  logic [63:0] press_cal_hi;
  logic [15:0] press_cal_nine;
  logic [31:0] hum_cal_lo;
  logic [39:0] hum_cal_hi;

  out_t        pending_words[$];
  int unsigned mismatches = 0;
  int unsigned send_idle_pct = 0;
  longint unsigned cycles = 0;

  env_sensor_compensation_32bit i_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .in_i, .valid_o, .out_o,
    .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic logic [31:0] ext16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] shr(logic [31:0] x, int n);
    return 32'($signed(x) >>> n);
  endfunction

  function automatic logic [31:0] mlo(logic [31:0] a, logic [31:0] b);
    logic [63:0] p;
    p = {32'd0, a} * {32'd0, b};
    return p[31:0];
  endfunction

  function automatic out_t compensate(in_t s);
    logic [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
    logic [31:0] h1, h2, h3, h4, h5, h6;
    logic [31:0] at, ap, ah, v1, v2, d, tf, sq, p, a, b, sc;
    out_t r;
    at = {12'd0, s.temp_reading};
    ap = {12'd0, s.press_reading};
    ah = {16'd0, s.hum_reading};
    t1 = {16'd0, temp_cal[15:0]};
    t2 = ext16(temp_cal[31:16]);
    t3 = ext16(temp_cal[47:32]);
    p1 = {16'd0, press_cal_lo[15:0]};
    p2 = ext16(press_cal_lo[31:16]);
    p3 = ext16(press_cal_lo[47:32]);
    p4 = ext16(press_cal_lo[63:48]);
    p5 = ext16(press_cal_hi[15:0]);
    p6 = ext16(press_cal_hi[31:16]);
    p7 = ext16(press_cal_hi[47:32]);
    p8 = ext16(press_cal_hi[63:48]);
    p9 = ext16(press_cal_nine);
    h1 = {24'd0, hum_cal_lo[7:0]};
    h2 = ext16(hum_cal_lo[23:8]);
    h3 = {24'd0, hum_cal_lo[31:24]};
    h4 = ext16(hum_cal_hi[15:0]);
    h5 = ext16(hum_cal_hi[31:16]);
    h6 = {{24{hum_cal_hi[39]}}, hum_cal_hi[39:32]};
    r = '0;
    p = 0;
    v1 = shr(mlo((at >> 3) - (t1 << 1), t2), 11);
    d = (at >> 4) - t1;
    v2 = shr(mlo(shr(mlo(d, d), 12), t3), 14);
    tf = v1 + v2;
    r.temp_centi = shr(mlo(tf, 32'd5) + 32'd128, 8);
    v1 = shr(tf, 1) - 32'd64000;
    d = shr(v1, 2);
    sq = mlo(d, d);
    v2 = mlo(shr(sq, 11), p6);
    v2 = v2 + (mlo(v1, p5) << 1);
    v2 = shr(v2, 2) + (p4 << 16);
    v1 = shr(shr(mlo(p3, shr(sq, 13)), 3) + shr(mlo(p2, v1), 1), 18);
    v1 = shr(mlo(32'd32768 + v1, p1), 15);
    if (v1 == 0) begin
      r.press_div_zero = 1'b1;
    end else begin
      p = mlo((32'd1048576 - ap) - shr(v2, 12), 32'd3125);
      if (p < 32'h8000_0000) p = (p << 1) / v1;
      else p = (p / v1) * 32'd2;
      d = p >> 3;
      v1 = shr(mlo(p9, mlo(d, d) >> 13), 12);
      v2 = shr(mlo(p >> 2, p8), 13);
      p = p + shr(v1 + v2 + p7, 4);
      p = p / 32'd100;
    end
    r.press_scaled = p[25:0];
    v1 = tf - 32'd76800;
    a = shr((ah << 14) - (h4 << 20) - mlo(h5, v1) + 32'd16384, 15);
    b = shr(mlo(shr(mlo(v1, h6), 10), shr(mlo(v1, h3), 11) + 32'd32768), 10) + 32'd2097152;
    b = shr(mlo(b, h2) + 32'd8192, 14);
    v1 = mlo(a, b);
    sc = shr(v1, 15);
    v1 = v1 - shr(mlo(shr(mlo(sc, sc), 7), h1), 4);
    if (v1[31]) v1 = 0;
    else if (v1 > 32'd419430400) v1 = 32'd419430400;
    v1 = (v1 >> 12) / 32'd1024;
    r.hum_percent = v1[6:0];
    return r;
  endfunction

  always @(posedge clk_i) begin
    out_t want;
    if (valid_o) begin
      if (pending_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word %h", out_o);
      end else begin
        want = pending_words.pop_front();
        if (out_o.temp_centi !== want.temp_centi || out_o.press_scaled !== want.press_scaled
            || out_o.hum_percent !== want.hum_percent
            || out_o.press_div_zero !== want.press_div_zero) begin
          mismatches++;
          if (mismatches <= 10) $display("word mismatch: expected %h actual %h", want, out_o);
        end
      end
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [63:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    case (idx)
      CfgTemp:      temp_cal = data[47:0];
      CfgPressLow:  press_cal_lo = data;
      CfgPressHigh: press_cal_hi = data;
      CfgPressNine: press_cal_nine = data[15:0];
      CfgHumLow:    hum_cal_lo = data[31:0];
      CfgHumHigh:   hum_cal_hi = data[39:0];
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain;
    while (pending_words.size() != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  task automatic send_sample(logic [19:0] t, logic [19:0] p, logic [15:0] h);
    in_t s;
    s.temp_reading = t;
    s.press_reading = p;
    s.hum_reading = h;
    while ($urandom_range(99) < send_idle_pct) begin
      @(posedge clk_i);
      start_i <= 1'b0;
    end
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    start_i <= 1'b1;
    in_i <= s;
    pending_words.push_back(compensate(s));
  endtask

  task automatic end_burst;
    @(posedge clk_i);
    start_i <= 1'b0;
  endtask

  task automatic load_typical;
    write_reg(CfgTemp, 64'({16'd50, 16'd26435, 16'd27504}));
    write_reg(CfgPressLow, {16'd2855, 16'hD0B3, 16'hD6D0, 16'd36477});
    write_reg(CfgPressHigh, {16'd15500, 16'hC1F8, 16'hFFF9, 16'd140});
    write_reg(CfgPressNine, 64'd6000);
    write_reg(CfgHumLow, 64'({8'd0, 16'd360, 8'd75}));
    write_reg(CfgHumHigh, 64'({8'd30, 16'd50, 16'd321}));
  endtask

  task automatic test_zero_coeffs;
    send_sample('0, '0, '0);
    send_sample('1, '1, '1);
    end_burst();
    drain();
  endtask

  task automatic test_directed;
    load_typical();
    send_sample(20'd519888, 20'd415148, 16'd27000);
    send_sample('0, '0, '0);
    send_sample('1, '1, '1);
    send_sample('0, '1, 16'hFFFF);
    send_sample('1, '0, 16'h0000);
    send_sample(20'h80000, 20'h80000, 16'h8000);
    send_sample(20'd400000, 20'd300000, 16'd60000);
    end_burst();
    drain();
    write_reg(CfgPressLow, {48'h1234_5678_9ABC, 16'd0});
    send_sample(20'd519888, 20'd415148, 16'd27000);
    end_burst();
    drain();
    write_reg(CfgTemp, 64'h0000_FFFF_FFFF_FFFF);
    write_reg(CfgPressLow, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(CfgPressHigh, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(CfgPressNine, 64'hFFFF);
    write_reg(CfgHumLow, 64'hFFFF_FFFF);
    write_reg(CfgHumHigh, 64'hFF_FFFF_FFFF);
    send_sample('0, '0, '0);
    send_sample('1, '1, '1);
    end_burst();
    drain();
    write_reg(CfgTemp, 64'({16'h8000, 16'h8000, 16'h0000}));
    write_reg(CfgPressLow, {16'h8000, 16'h8000, 16'h8000, 16'hFFFF});
    write_reg(CfgPressHigh, {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000});
    write_reg(CfgPressNine, 64'h8000);
    write_reg(CfgHumLow, 64'({8'hFF, 16'h7FFF, 8'h00}));
    write_reg(CfgHumHigh, 64'({8'h80, 16'h7FFF, 16'h8000}));
    send_sample('1, '0, 16'hFFFF);
    send_sample(20'h7FFFF, 20'h7FFFF, 16'h7FFF);
    end_burst();
    drain();
  endtask

  task automatic random_phase(int unsigned n, bit rand_cfg);
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 130 == 0) begin
        end_burst();
        drain();
        if (rand_cfg && $urandom_range(1) == 1) begin
          write_reg(CfgTemp, {$urandom(), $urandom()});
          write_reg(CfgPressLow, {$urandom(), $urandom()});
          write_reg(CfgPressHigh, {$urandom(), $urandom()});
          write_reg(CfgPressNine, {32'd0, $urandom()});
          write_reg(CfgHumLow, {32'd0, $urandom()});
          write_reg(CfgHumHigh, {$urandom(), $urandom()});
        end else begin
          load_typical();
        end
      end
      if ($urandom_range(3) == 0)
        send_sample(20'($urandom()), 20'($urandom()), 16'($urandom()));
      else
        send_sample(20'(20'd480000 + $urandom_range(80000)),
                    20'(20'd250000 + $urandom_range(250000)),
                    16'(16'd20000 + $urandom_range(30000)));
    end
    end_burst();
    drain();
  endtask

  initial begin
    temp_cal = '0;
    press_cal_lo = '0;
    press_cal_hi = '0;
    press_cal_nine = '0;
    hum_cal_lo = '0;
    hum_cal_hi = '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_zero_coeffs();
    test_directed();
    send_idle_pct = 23;
    random_phase(520, 1'b1);
    send_idle_pct = 59;
    random_phase(520, 1'b1);
    send_idle_pct = 0;
    random_phase(520, 1'b1);
    drain();
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

@@ env_sensor_compensation_32bit.f @@
rtl/ecs_pkg.sv
rtl/ecs_div.sv
rtl/env_sensor_compensation_32bit.sv
verif/tb.sv
